### design/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
`timescale 1ns / 1ps

package bole_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    CMD_INSERT       = 2'd0,
    CMD_REMOVE_AT    = 2'd1,
    CMD_REMOVE_MATCH = 2'd2,
    CMD_READ         = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [4:0]  position;
    logic [31:0] item_value;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  entry_count;
    logic [3:0]  match_position;
    logic [31:0] read_value;
  } result_t;

  // Shift controls broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

### design/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: control, count and a row of cells.
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid/req_ready/req) carries one request: cmd, position,
//   item_value. rsp channel (rsp_valid/rsp_ready/rsp) returns one result per
//   request: status, entry_count, match_position, read_value.
//   Insert, remove-at-index and read finish in the accept cycle; the result
//   is registered and shows in the next cycle, so throughput is one request
//   per cycle while the receiver keeps up.
//   Remove-first-match walks the latched compare flags one cell per cycle
//   until it finds a match or reaches count, then returns its result once
//   the output register is free.
//   The next request is taken while a result still waits in the output
//   register, provided that register is taken in the same cycle.
//   Reset (rst, synchronous) empties the list and drops any pending result;
//   entry storage itself is not cleared since only live entries are read.
//   A stalled receiver holds the result; req_ready stays low until it frees.
module bounded_ordered_list_engine #(
  parameter int CAPACITY    = bole_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bole_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bole_pkg::request_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output bole_pkg::result_t  rsp
);
  import bole_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);   // count width, holds CAPACITY
  localparam int IW = $clog2(CAPACITY);       // cell index width
  localparam int PW = (CW > 5) ? CW : 5;      // compare width for position vs count

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] scan_idx;
  logic [CAPACITY-1:0] mvec;

  logic                   out_free;
  logic                   accept;
  logic                   done;
  result_t                res;
  cell_ctl_t              ctl;
  logic [IW-1:0]          cell_pos;
  logic [VALUE_WIDTH-1:0] key;
  logic [VALUE_WIDTH-1:0] rd_sel;
  logic [PW-1:0]          pos_ext;
  logic [PW-1:0]          cnt_ext;

  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]    cell_match;

  // The output register is free when empty or being emptied this cycle.
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign accept    = req_valid && req_ready;

  // Cut the request value to the stored width; it is both insert data and key.
  assign key     = VALUE_WIDTH'(req.item_value);
  assign pos_ext = PW'(req.position);
  assign cnt_ext = PW'(count);

  // Row of cells; each takes from its lower neighbor on insert, upper on delete.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lower_v;
    logic [VALUE_WIDTH-1:0] upper_v;
    if (i == 0) begin : g_first
      assign lower_v = key;
    end else begin : g_mid_lo
      assign lower_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_v = cell_val[i];
    end else begin : g_mid_hi
      assign upper_v = cell_val[i+1];
    end
    bole_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .IW         (IW),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .pos      (cell_pos),
      .new_value(key),
      .lower    (lower_v),
      .upper    (upper_v),
      .key      (key),
      .value    (cell_val[i]),
      .match    (cell_match[i])
    );
  end

  // Read port: each cell gates its own value by its index, then OR them together.
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | (cell_val[i] & {VALUE_WIDTH{cell_pos == IW'(i)}});
    end
  end

  // Command decode and result formation.
  always_comb begin
    ctl        = '0;
    cell_pos   = IW'(req.position);
    count_next = count;
    done       = 1'b0;
    res        = '0;
    res.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.cmd)
            CMD_INSERT: begin
              done = 1'b1;
              if (pos_ext > cnt_ext) begin
                res.status = ST_BAD_INDEX;
              end else if (cnt_ext == PW'(CAPACITY)) begin
                res.status = ST_FULL;
              end else begin
                ctl.ins    = 1'b1;
                count_next = count + CW'(1);
              end
            end
            CMD_REMOVE_AT: begin
              done = 1'b1;
              if (pos_ext >= cnt_ext) begin
                res.status = ST_BAD_INDEX;
              end else begin
                ctl.del    = 1'b1;
                count_next = count - CW'(1);
              end
            end
            CMD_REMOVE_MATCH: begin
              // Latch compare flags and hand over to the scan.
            end
            CMD_READ: begin
              done = 1'b1;
              if (pos_ext >= cnt_ext) begin
                res.status = ST_BAD_INDEX;
              end else begin
                res.read_value = 32'(rd_sel);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cell_pos = IW'(scan_idx);
        if (out_free) begin
          if (scan_idx == count) begin
            done       = 1'b1;
            res.status = ST_NOT_FOUND;
          end else if (mvec[0]) begin
            done               = 1'b1;
            ctl.del            = 1'b1;
            count_next         = count - CW'(1);
            res.match_position = 4'(scan_idx);
          end
        end
      end
      default: begin
      end
    endcase
    res.entry_count = 5'(count_next);
  end

  // State, count and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (done) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && req.cmd == CMD_REMOVE_MATCH) begin
            state    <= S_SCAN;
            scan_idx <= '0;
            mvec     <= cell_match;
          end
        end
        S_SCAN: begin
          if (done) begin
            state <= S_IDLE;
          end else if (scan_idx != count && !mvec[0]) begin
            // Advance to the next cell flag.
            mvec     <= mvec >> 1;
            scan_idx <= scan_idx + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/bole_cell.sv
// One list cell: holds one entry, shifts from a neighbor, compares against a key.
`timescale 1ns / 1ps

module bole_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int IW          = 4,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  bole_pkg::cell_ctl_t    ctl,
  input  logic [IW-1:0]          pos,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [VALUE_WIDTH-1:0] lower,
  input  logic [VALUE_WIDTH-1:0] upper,
  input  logic [VALUE_WIDTH-1:0] key,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   match
);
  import bole_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VALUE_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    if (ctl.ins) begin
      if (MY_IDX > pos) value_next = lower;
      else if (MY_IDX == pos) value_next = new_value;
    end else if (ctl.del) begin
      if (MY_IDX >= pos) value_next = upper;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign match = (value == key);

endmodule

### tb/bole_result_checker.sv
// Result checker for the bounded ordered list engine: predicts and compares every result.
`timescale 1ns / 1ps

module bole_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  bole_pkg::request_t req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  bole_pkg::result_t  rsp,
  output int                 failures,
  output int                 pending
);
  import bole_pkg::*;

  localparam int unsigned DEPTH = CAPACITY_DEF;

  logic [31:0] shadow_list [DEPTH];
  int unsigned shadow_len = 0;
  result_t     expected_q [$];
  result_t     want;
  int          mismatches = 0;

  // Drop the entry at a live position and close the gap behind it.
  task automatic close_gap(input int unsigned at);
    int unsigned k;
    for (k = at; k + 1 < shadow_len; k++) begin
      shadow_list[k] = shadow_list[k + 1];
    end
    shadow_len--;
  endtask

  // Apply one request to the shadow list and return the result it should give.
  task automatic predict_result(input request_t r, output result_t res);
    int unsigned pos;
    int unsigned k;
    bit hit;
    pos = 32'(r.position);
    res = '0;
    hit = 1'b0;
    case (r.cmd)
      CMD_INSERT: begin
        if (pos > shadow_len) begin
          res.status = ST_BAD_INDEX;
        end else if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > pos; k--) begin
            shadow_list[k] = shadow_list[k - 1];
          end
          shadow_list[pos] = r.item_value;
          shadow_len++;
        end
      end
      CMD_REMOVE_AT: begin
        if (pos >= shadow_len) begin
          res.status = ST_BAD_INDEX;
        end else begin
          close_gap(pos);
        end
      end
      CMD_REMOVE_MATCH: begin
        for (k = 0; k < shadow_len && !hit; k++) begin
          if (shadow_list[k] == r.item_value) begin
            hit = 1'b1;
            res.match_position = 4'(k);
            close_gap(k);
          end
        end
        if (!hit) begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (pos >= shadow_len) begin
          res.status = ST_BAD_INDEX;
        end else begin
          res.read_value = shadow_list[pos];
        end
      end
    endcase
    res.entry_count = 5'(shadow_len);
  endtask

  // Results are taken first: a result never shares an edge with its own request.
  always @(posedge clk) begin
    if (rst) begin
      shadow_len = 0;
      expected_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request waiting: status %0d count %0d",
                 rsp.status, rsp.entry_count);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (rsp.status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.entry_count != want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, rsp.entry_count);
            mismatches++;
          end
          if (rsp.match_position != want.match_position) begin
            $error("match_position: expected %0d, actual %0d",
                   want.match_position, rsp.match_position);
            mismatches++;
          end
          if (rsp.read_value != want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, rsp.read_value);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready) begin
        predict_result(req, want);
        expected_q.push_back(want);
      end
    end
    failures <= mismatches;
    pending  <= expected_q.size();
  end

endmodule

### tb/tb.sv
// Testbench top for the bounded ordered list engine: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
  import bole_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1250;
  // Tail wait after the drain; leaves ample slack over the longest match scan.
  localparam int TAIL_CYCLES  = 40;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  request_t req       = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  result_t  rsp;

  int          failures;
  int          pending;
  int          stall_cycles = 0;
  bit          steady       = 1'b0;
  int unsigned live_count   = 0;

  // Small value pool so that duplicates, and therefore real match removals, are common.
  logic [31:0] value_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
                                  32'h5A5A_5A5A, 32'h0000_0001, 32'h8000_0000};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_ordered_list_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  bole_result_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .failures  (failures),
    .pending   (pending)
  );

  // Receiver: stall at random about ten percent of the time, never during the steady stretch.
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // Track the list size from returned results; it lags a little and only
  // steers the fill or drain phase and the choice of positions, never a check.
  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      live_count <= 32'(rsp.entry_count);
    end
  end

  // Watchdog: end the run when no request and no result moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Present one request, hold it until taken, then idle now and then.
  task automatic issue(input cmd_t op, input logic [4:0] pos, input logic [31:0] val);
    req       <= '{cmd: op, position: pos, item_value: val};
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (!steady && $urandom_range(0, 99) < 10) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result has come back.
  // Wait for a clock edge first so the last accepted request is counted.
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int unsigned i;
    int          pct;
    cmd_t        op;
    logic [4:0]  pos;
    logic [31:0] val;
    bit          filling;

    filling = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: read, remove-at and remove-match on an empty list fail cleanly.
    issue(CMD_READ, 5'd0, 32'h0);
    issue(CMD_REMOVE_AT, 5'd0, 32'h0);
    issue(CMD_REMOVE_MATCH, 5'd0, 32'h0);
    // Insert past the end of an empty list.
    issue(CMD_INSERT, 5'd1, 32'hDEAD_BEEF);
    // Fill to capacity, mixing front inserts and appends; the all-ones value
    // goes last and stays unique so a match removal can hit the top position.
    for (i = 0; i < CAPACITY; i++) begin
      issue(CMD_INSERT, (i % 3 == 1) ? 5'd0 : 5'(i),
            (i == CAPACITY - 1) ? 32'hFFFF_FFFF :
            (i % 2 == 1) ? 32'h0 : 32'hA5A5_0000 + i);
    end
    // Insert into a full list, then past the end of it (index wins over full).
    issue(CMD_INSERT, 5'd16, 32'h1);
    issue(CMD_INSERT, 5'd17, 32'h1);
    issue(CMD_READ, 5'd15, 32'h0);
    issue(CMD_REMOVE_MATCH, 5'd0, 32'hFFFF_FFFF);
    issue(CMD_REMOVE_AT, 5'd0, 32'h0);
    issue(CMD_REMOVE_MATCH, 5'd0, 32'h0);
    settle();

    // Random: sweep the list between empty and full with mostly legal
    // positions and pooled values; one position in ten, three values in twenty are noise.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 500 && n < 750);
      if (n % 400 == 200) begin
        settle();
      end
      if (filling && live_count >= CAPACITY && $urandom_range(0, 3) == 0) begin
        filling = 1'b0;
      end else if (!filling && live_count == 0 && $urandom_range(0, 3) == 0) begin
        filling = 1'b1;
      end

      pct = $urandom_range(0, 99);
      if (filling) begin
        op = (pct < 50) ? CMD_INSERT : (pct < 60) ? CMD_REMOVE_AT :
             (pct < 75) ? CMD_REMOVE_MATCH : CMD_READ;
      end else begin
        op = (pct < 10) ? CMD_INSERT : (pct < 45) ? CMD_REMOVE_AT :
             (pct < 75) ? CMD_REMOVE_MATCH : CMD_READ;
      end

      if ($urandom_range(0, 99) < 10) begin
        pos = 5'($urandom_range(0, 31));
      end else if (op == CMD_INSERT) begin
        pos = 5'($urandom_range(0, live_count));
      end else begin
        pos = (live_count == 0) ? 5'd0 : 5'($urandom_range(0, live_count - 1));
      end

      if ($urandom_range(0, 99) < 85) begin
        val = value_pool[$urandom_range(0, 5)];
      end else begin
        val = $urandom();
      end

      issue(op, pos, val);
    end

    // Drain: wait out every result, then the longest scan plus margin.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
